// ----- design/lusl_pkg.sv -----
package lusl_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 16;
  localparam int unsigned NumSymbols = 1 << ByteW;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;

  // Result of one byte, held in the output register
  typedef struct packed {
    logic done;
    logic ovf;
    pos_t win;
    pos_t best;
  } result_t;

endpackage

// ----- design/lusl_ram.sv -----
module lusl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/longest_unique_substring_length_top.sv -----
// Longest repeat-free substring length over a byte stream.
//
// Input channel (s_axis_*): one byte of a string per transfer; tlast marks the
// final byte of the string. Output channel (m_axis_*): one result per input
// byte, in order: best length so far and current window length in tdata, the
// overflow flag in tuser, and tlast set on the result that closes the string.
//
// The byte and its table read are registered into the update stage, and the
// update result into the output register. One byte is taken per cycle while
// the receiver keeps up: the last-position table read is issued as the byte is
// taken, the update stage then computes and writes the table back, and a
// one-entry bypass covers a byte repeated in the very next transfer.
// Seen flags sit in flip-flops and are all cleared together at end of string.
//
// Reset clears all control state and the seen flags; the table needs no
// clearing pass, so bytes are taken as soon as reset is released.
// A stalled receiver holds the result in the output register; the update
// stage then holds its byte and the input side stops taking transfers.
module longest_unique_substring_length_top #(
  parameter int unsigned MAX_CHARS = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] best_length, [31:16] window_length
  output logic        m_axis_tuser,   // length_overflow
  output logic        m_axis_tlast    // string_done
);

  localparam lusl_pkg::pos_t PosLimit =
    (MAX_CHARS > 32'd65535) ? 16'hFFFF : lusl_pkg::pos_t'(MAX_CHARS);

  logic s_fire;
  logic s1_adv;

  // update stage
  logic              s1_valid_q;
  lusl_pkg::byte_t   s1_byte_q;
  logic              s1_last_q;

  // string state
  logic [lusl_pkg::NumSymbols-1:0] seen_q, seen_d;
  lusl_pkg::pos_t    ws_q, ws_d;
  lusl_pkg::pos_t    bp_q, bp_d;
  lusl_pkg::pos_t    best_q, best_d;
  logic              ovf_q, ovf_d;

  // last table write, for a read issued on the same edge
  logic              byp_valid_q;
  lusl_pkg::byte_t   byp_byte_q;
  lusl_pkg::pos_t    byp_pos_q;

  logic              out_valid_q;
  lusl_pkg::result_t out_q, res;

  lusl_pkg::pos_t    ram_rdata;
  lusl_pkg::pos_t    last_pos;
  logic [lusl_pkg::PosW:0] cand;
  lusl_pkg::pos_t    start;
  lusl_pkg::pos_t    win;
  logic              ovf_now;
  logic              wr_en;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  lusl_ram #(
    .Width(lusl_pkg::PosW),
    .Depth(lusl_pkg::NumSymbols)
  ) u_last_pos (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_byte_q),
    .wdata_i(bp_q),
    .re_i   (s_fire),
    .raddr_i(s_axis_tdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    ovf_now  = ovf_q || (bp_q >= PosLimit);
    last_pos = (byp_valid_q && (byp_byte_q == s1_byte_q)) ? byp_pos_q : ram_rdata;
    cand     = {1'b0, last_pos} + 17'd1;
    start    = ws_q;
    if (seen_q[s1_byte_q] && (cand > {1'b0, ws_q})) begin
      start = cand[lusl_pkg::PosW-1:0];
    end

    ws_d   = ws_q;
    bp_d   = bp_q;
    best_d = best_q;
    ovf_d  = ovf_q;
    seen_d = seen_q;
    wr_en  = 1'b0;

    if (ovf_now) begin
      ovf_d = 1'b1;
      win   = (bp_q >= ws_q) ? (bp_q - ws_q) : '0;
    end else begin
      win   = bp_q - start + 16'd1;
      wr_en = s1_adv;
      ws_d  = start;
      bp_d  = bp_q + 16'd1;
      seen_d[s1_byte_q] = 1'b1;
      if (win > best_q) begin
        best_d = win;
      end
    end

    res.best = best_d;
    res.win  = win;
    res.ovf  = ovf_d;
    res.done = s1_last_q;

    if (s1_last_q) begin
      ws_d   = '0;
      bp_d   = '0;
      best_d = '0;
      ovf_d  = 1'b0;
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_valid_q <= 1'b0;
      seen_q      <= '0;
      ws_q        <= '0;
      bp_q        <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        seen_q      <= seen_d;
        ws_q        <= ws_d;
        bp_q        <= bp_d;
        best_q      <= best_d;
        ovf_q       <= ovf_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        byp_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_byte_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
    if (wr_en) begin
      byp_byte_q <= s1_byte_q;
      byp_pos_q  <= bp_q;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.win, out_q.best};
  assign m_axis_tuser  = out_q.ovf;
  assign m_axis_tlast  = out_q.done;

endmodule
